[rtl/i2crr_pkg.sv]
package i2crr_pkg;

    typedef enum logic [4:0] {
        P_IDLE, P_ST_A, P_ST_B, P_ST_C, P_TX_SET, P_TX_HIGH, P_TX_LOW,
        P_RA_LOW, P_RA_HIGH, P_RA_POLL, P_RA_END, P_GAP,
        P_RX_REL, P_RX_HIGH, P_RX_LOW, P_AK_SET, P_AK_HIGH, P_AK_LOW,
        P_SP_A, P_SP_B, P_SP_C
    } t_phase;

    localparam logic [1:0] CFG_SHORT_WAIT  = 2'd0;
    localparam logic [1:0] CFG_BIT_WAIT    = 2'd1;
    localparam logic [1:0] CFG_RESTART_GAP = 2'd2;
    localparam logic [1:0] CFG_ACK_TIMEOUT = 2'd3;

    localparam int QUEUE_DEPTH = 2;

    // one tick request as held in the queue
    typedef struct packed {
        logic       action;
        logic       sda_in;
        logic [6:0] slave_address;
        logic [7:0] register_address;
        logic [7:0] byte_count;
    } t_tick;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_drive;
        logic       byte_valid;
        logic [7:0] rx_byte;
        logic       last_byte;
        logic       busy_res;
        logic       done_res;
        logic       error;
    } t_result;

    typedef struct packed {
        logic [15:0] short_wait;
        logic [15:0] bit_wait;
        logic [15:0] restart_gap;
        logic [15:0] ack_timeout;
    } t_cfg;

endpackage

[rtl/i2crr_front.sv]
module i2crr_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  i2crr_pkg::t_tick     i_tick,
    output logic                 o_q_valid,
    input  logic                 i_q_take,
    output i2crr_pkg::t_tick     o_q_tick
);
    // two entry queue between request intake and the bus sequencer
    i2crr_pkg::t_tick r_mem [i2crr_pkg::QUEUE_DEPTH];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic push, pop;

    assign o_stall   = (r_cnt == 2'(i2crr_pkg::QUEUE_DEPTH));
    assign push      = i_valid && !o_stall;
    assign pop       = i_q_take && (r_cnt != 2'd0);
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_tick  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_tick;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end
endmodule

[rtl/i2crr_seq.sv]
module i2crr_seq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  i2crr_pkg::t_cfg      i_cfg,
    input  logic                 i_q_valid,
    output logic                 o_q_take,
    input  i2crr_pkg::t_tick     i_tick,
    output logic                 o_valid,
    input  logic                 i_stall,
    output i2crr_pkg::t_result   o_res
);
    i2crr_pkg::t_phase r_phase, n_phase;
    logic [15:0] r_wait, n_wait;
    logic [16:0] r_poll, n_poll;
    logic [2:0]  r_bit, n_bit;
    logic [7:0]  r_shift, n_shift, r_left, n_left;
    logic [6:0]  r_slave, n_slave;
    logic [7:0]  r_reg, n_reg;
    logic [1:0]  r_stage, n_stage;
    logic        r_failed, n_failed;
    logic        r_ovalid;
    i2crr_pkg::t_result r_res, res;
    logic step, ended;
    logic [15:0] wait_inc, plen, wsel;
    logic txbit, akbit;
    i2crr_pkg::t_phase target, entered;

    assign o_q_take = i_q_valid && (!r_ovalid || !i_stall);
    assign step     = o_q_take;
    assign o_valid  = r_ovalid;
    assign o_res    = r_res;

    assign txbit = r_shift[3'd7 - r_bit];
    assign akbit = (r_left <= 8'd1);

    // output levels from phase in force, plus received byte, busy, done and error flags
    always_comb begin
        res = '0;
        res.scl_level = 1'b0;
        res.sda_level = 1'b1;
        res.sda_drive = 1'b1;
        case (r_phase)
            i2crr_pkg::P_IDLE, i2crr_pkg::P_ST_A, i2crr_pkg::P_SP_C: res.scl_level = 1'b1;
            i2crr_pkg::P_ST_B, i2crr_pkg::P_SP_B: begin
                res.scl_level = 1'b1;
                res.sda_level = 1'b0;
            end
            i2crr_pkg::P_ST_C, i2crr_pkg::P_SP_A: res.sda_level = 1'b0;
            i2crr_pkg::P_TX_SET, i2crr_pkg::P_TX_LOW: res.sda_level = txbit;
            i2crr_pkg::P_TX_HIGH: begin
                res.scl_level = 1'b1;
                res.sda_level = txbit;
            end
            i2crr_pkg::P_RA_HIGH, i2crr_pkg::P_RA_POLL, i2crr_pkg::P_RX_HIGH: begin
                res.scl_level = 1'b1;
                res.sda_drive = 1'b0;
            end
            i2crr_pkg::P_RA_LOW, i2crr_pkg::P_RA_END, i2crr_pkg::P_GAP,
            i2crr_pkg::P_RX_REL, i2crr_pkg::P_RX_LOW: res.sda_drive = 1'b0;
            i2crr_pkg::P_AK_SET, i2crr_pkg::P_AK_LOW: res.sda_level = akbit;
            i2crr_pkg::P_AK_HIGH: begin
                res.scl_level = 1'b1;
                res.sda_level = akbit;
            end
            default: res.scl_level = 1'b1;
        endcase
        res.byte_valid = 1'b0;
        if (r_phase == i2crr_pkg::P_RX_HIGH && ended && r_bit == 3'd7) begin
            res.byte_valid = 1'b1;
            res.rx_byte    = {r_shift[6:0], i_tick.sda_in};
            res.last_byte  = akbit;
        end
        if (r_phase == i2crr_pkg::P_SP_C && ended) begin
            res.done_res = 1'b1;
            res.error    = r_failed;
        end
        res.busy_res = (n_phase != i2crr_pkg::P_IDLE);
    end

    always_comb begin
        case (r_phase)
            i2crr_pkg::P_TX_SET, i2crr_pkg::P_TX_HIGH, i2crr_pkg::P_TX_LOW,
            i2crr_pkg::P_RX_REL, i2crr_pkg::P_RX_HIGH, i2crr_pkg::P_RX_LOW:
                wsel = i_cfg.bit_wait;
            i2crr_pkg::P_GAP: wsel = i_cfg.restart_gap;
            default: wsel = i_cfg.short_wait;
        endcase
        plen     = (wsel == 16'd0) ? 16'd1 : wsel;
        wait_inc = r_wait + 16'd1;
        ended    = (wait_inc == 16'd0) || (wait_inc >= plen);
    end

    // next state
    always_comb begin
        n_phase = r_phase; n_wait = r_wait; n_poll = r_poll; n_bit = r_bit;
        n_shift = r_shift; n_left = r_left; n_slave = r_slave; n_reg = r_reg;
        n_stage = r_stage; n_failed = r_failed;
        target = r_phase;
        entered = r_phase;
        if (r_phase == i2crr_pkg::P_IDLE) begin
            if (i_tick.action) begin
                n_slave  = i_tick.slave_address;
                n_reg    = i_tick.register_address;
                n_left   = (i_tick.byte_count == 8'd0) ? 8'd1 : i_tick.byte_count;
                n_stage  = 2'd0;
                n_failed = 1'b0;
                n_shift  = {i_tick.slave_address, 1'b0};
                n_bit    = 3'd0;
                target   = i2crr_pkg::P_ST_A;
            end
        end else if (r_phase == i2crr_pkg::P_RA_POLL) begin
            if (!i_tick.sda_in) begin
                target = i2crr_pkg::P_RA_END;
            end else if (r_poll > {1'b0, i_cfg.ack_timeout}) begin
                n_failed = 1'b1;
                target   = i2crr_pkg::P_RA_END;
            end else begin
                n_poll = r_poll + 17'd1;
            end
        end else begin
            n_wait = wait_inc;
            if (ended) begin
                case (r_phase)
                    i2crr_pkg::P_ST_A: target = i2crr_pkg::P_ST_B;
                    i2crr_pkg::P_ST_B: target = i2crr_pkg::P_ST_C;
                    i2crr_pkg::P_ST_C: begin
                        n_bit = 3'd0; target = i2crr_pkg::P_TX_SET;
                    end
                    i2crr_pkg::P_TX_SET: target = i2crr_pkg::P_TX_HIGH;
                    i2crr_pkg::P_TX_HIGH: target = i2crr_pkg::P_TX_LOW;
                    i2crr_pkg::P_TX_LOW:
                        if (r_bit == 3'd7) target = i2crr_pkg::P_RA_LOW;
                        else begin
                            n_bit = r_bit + 3'd1; target = i2crr_pkg::P_TX_SET;
                        end
                    i2crr_pkg::P_RA_LOW: target = i2crr_pkg::P_RA_HIGH;
                    i2crr_pkg::P_RA_HIGH: begin
                        n_poll = '0; target = i2crr_pkg::P_RA_POLL;
                    end
                    i2crr_pkg::P_RA_END:
                        if (r_failed) target = i2crr_pkg::P_SP_A;
                        else if (r_stage == 2'd0) begin
                            n_stage = 2'd1; n_shift = r_reg; n_bit = 3'd0;
                            target = i2crr_pkg::P_TX_SET;
                        end else if (r_stage == 2'd1) begin
                            n_stage = 2'd2; target = i2crr_pkg::P_GAP;
                        end else begin
                            n_bit = 3'd0; n_shift = '0; target = i2crr_pkg::P_RX_REL;
                        end
                    i2crr_pkg::P_GAP: target = i2crr_pkg::P_ST_A;
                    i2crr_pkg::P_RX_REL: target = i2crr_pkg::P_RX_HIGH;
                    i2crr_pkg::P_RX_HIGH: begin
                        n_shift = {r_shift[6:0], i_tick.sda_in};
                        target  = i2crr_pkg::P_RX_LOW;
                    end
                    i2crr_pkg::P_RX_LOW:
                        if (r_bit == 3'd7) target = i2crr_pkg::P_AK_SET;
                        else begin
                            n_bit = r_bit + 3'd1; target = i2crr_pkg::P_RX_HIGH;
                        end
                    i2crr_pkg::P_AK_SET: target = i2crr_pkg::P_AK_HIGH;
                    i2crr_pkg::P_AK_HIGH: target = i2crr_pkg::P_AK_LOW;
                    i2crr_pkg::P_AK_LOW:
                        if (r_left > 8'd1) begin
                            n_left = r_left - 8'd1; n_bit = 3'd0; n_shift = '0;
                            target = i2crr_pkg::P_RX_REL;
                        end else target = i2crr_pkg::P_SP_A;
                    i2crr_pkg::P_SP_A: target = i2crr_pkg::P_SP_B;
                    i2crr_pkg::P_SP_B: target = i2crr_pkg::P_SP_C;
                    default: begin
                        n_failed = 1'b0; n_stage = 2'd0;
                        target = i2crr_pkg::P_IDLE;
                    end
                endcase
            end
        end
        // phase entry with gap skip and read address load
        if (target != r_phase || (ended && r_phase != i2crr_pkg::P_IDLE
                                  && r_phase != i2crr_pkg::P_RA_POLL)) begin
            entered = target;
            if (entered == i2crr_pkg::P_GAP && i_cfg.restart_gap == 16'd0)
                entered = i2crr_pkg::P_ST_A;
            if (entered == i2crr_pkg::P_ST_A && n_stage == 2'd2)
                n_shift = {n_slave, 1'b1};
            n_wait = '0;
        end
        n_phase = entered;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= i2crr_pkg::P_IDLE;
            r_wait <= '0; r_poll <= '0; r_bit <= '0; r_shift <= '0;
            r_left <= '0; r_slave <= '0; r_reg <= '0; r_stage <= '0;
            r_failed <= 1'b0; r_ovalid <= 1'b0;
        end else begin
            if (step) begin
                r_phase <= n_phase; r_wait <= n_wait; r_poll <= n_poll;
                r_bit <= n_bit; r_shift <= n_shift; r_left <= n_left;
                r_slave <= n_slave; r_reg <= n_reg; r_stage <= n_stage;
                r_failed <= n_failed;
            end
            if (step) r_ovalid <= 1'b1;
            else if (!i_stall) r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) r_res <= res;
    end
endmodule

[rtl/i2c_register_read_master.sv]
// channel | handshake           | payload
// tick in | i_valid / o_stall   | action, sda_in, slave/register address, byte count
// result  | o_valid / i_stall   | line levels, received byte, busy, done, error
// config  | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
// one tick per cycle sustained while the output is not stalled; a request passes through the two entry queue and its
// result is registered as the sequencer takes it, so it is offered from the next cycle
// synchronous active-low reset returns the bus to idle with default timings
// output stall holds the result register and backs the queue up to the input
module i2c_register_read_master (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_action,
    input  logic        i_sda_in,
    input  logic [6:0]  i_slave_address,
    input  logic [7:0]  i_register_address,
    input  logic [7:0]  i_byte_count,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_scl_level,
    output logic        o_sda_level,
    output logic        o_sda_drive,
    output logic        o_byte_valid,
    output logic [7:0]  o_rx_byte,
    output logic        o_last_byte,
    output logic        o_busy_res,
    output logic        o_done_res,
    output logic        o_error,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    i2crr_pkg::t_tick   in_tick, q_tick;
    i2crr_pkg::t_result res;
    i2crr_pkg::t_cfg    r_cfg;
    logic q_valid, q_take;

    assign in_tick = '{action: i_action, sda_in: i_sda_in,
                       slave_address: i_slave_address,
                       register_address: i_register_address,
                       byte_count: i_byte_count};

    // timing registers, to be written only while idle; the block itself does not enforce this
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.short_wait  <= 16'd5;
            r_cfg.bit_wait    <= 16'd15;
            r_cfg.restart_gap <= 16'd100;
            r_cfg.ack_timeout <= 16'd1000;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                i2crr_pkg::CFG_SHORT_WAIT:  r_cfg.short_wait  <= i_cfg_data;
                i2crr_pkg::CFG_BIT_WAIT:    r_cfg.bit_wait    <= i_cfg_data;
                i2crr_pkg::CFG_RESTART_GAP: r_cfg.restart_gap <= i_cfg_data;
                i2crr_pkg::CFG_ACK_TIMEOUT: r_cfg.ack_timeout <= i_cfg_data;
                default: ;
            endcase
        end
    end

    i2crr_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_tick(in_tick),
        .o_q_valid(q_valid), .i_q_take(q_take), .o_q_tick(q_tick)
    );

    i2crr_seq u_seq (
        .i_clk, .i_rst_n, .i_cfg(r_cfg), .i_q_valid(q_valid), .o_q_take(q_take),
        .i_tick(q_tick), .o_valid, .i_stall, .o_res(res)
    );

    assign o_scl_level  = res.scl_level;
    assign o_sda_level  = res.sda_level;
    assign o_sda_drive  = res.sda_drive;
    assign o_byte_valid = res.byte_valid;
    assign o_rx_byte    = res.rx_byte;
    assign o_last_byte  = res.last_byte;
    assign o_busy_res   = res.busy_res;
    assign o_done_res   = res.done_res;
    assign o_error      = res.error;

    // error only reported with done
    a_err_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_error |-> o_done_res) else $error("error without done");
    // done ends the transaction
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_done_res |-> !o_busy_res) else $error("busy after done");
    // last flag only with a byte
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last_byte |-> o_byte_valid) else $error("stray last flag");
endmodule
